// File: rtl/lzss_pkg.sv
// types and constants shared by the lzss byte decompressor
// no dependencies; compile first
`timescale 1ns / 1ps

package lzss_pkg;

    // history window geometry, fixed by the 12-bit distance of a match word
    localparam int WINDOW_BYTES = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);

    // match length field and bias
    localparam int LEN_W = 5;
    localparam logic [LEN_W-1:0] MIN_LEN  = LEN_W'(3);
    localparam logic [3:0]       LEN_MASK = 4'hF;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // parser phase
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_WORD  = 2'd2
    } phase_t;

    // controller state, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    // compressed stream request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_item_t;

    // decompressed result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic       run_last;
    } out_item_t;

    // window memory access from the controller
    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } mem_req_t;

endpackage

// File: rtl/lzss_stream_if.sv
// valid/ready channel carrying one request of a given payload type
// no dependencies; payload types come from lzss_pkg at instantiation
`timescale 1ns / 1ps

interface lzss_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lzss_window_ram.sv
// history window: one write port, one read port, registered read data
// depends on lzss_pkg
`timescale 1ns / 1ps

module lzss_window_ram
    import lzss_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem [WINDOW_BYTES];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// File: rtl/lzss_ctrl.sv
// token parser, match copy sequencer and result register
// depends on lzss_pkg and lzss_stream_if; drives lzss_window_ram
`timescale 1ns / 1ps

module lzss_ctrl
    import lzss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lzss_stream_if.sink          stream,
    lzss_stream_if.source        result,
    output mem_req_t             mem_req,
    input  logic [7:0]           mem_rdata
);

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        flags_reg, flags_next;
    logic [2:0]        tok_idx_reg, tok_idx_next;
    logic [7:0]        word_high_reg, word_high_next;
    logic              finished_reg, finished_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic              full_reg, full_next;
    logic              end_reg, end_next;
    logic [WIN_AW-1:0] src_reg, src_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic [LEN_W-1:0]  emit_left_reg, emit_left_next;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;
    logic              rvalid_reg, rvalid_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              out_free;
    logic              accept;
    logic [7:0]        b;
    logic              e;
    logic [15:0]       word;
    logic [LEN_W-1:0]  len;
    logic [WIN_AW-1:0] start_src;
    logic [7:0]        copy_d;
    logic              do_reset;

    // handshake
    assign out_free     = !out_valid_reg || result.ready;
    assign stream.ready = (state_reg == ST_IDLE) && out_free;
    assign accept       = stream.valid && stream.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // token decode
    assign b         = stream.data.in_byte;
    assign e         = stream.data.stream_end;
    assign word      = {word_high_reg, b};
    assign len       = {1'b0, word[3:0] & LEN_MASK} + MIN_LEN;
    assign start_src = wp_reg - WIN_AW'(word[15:4]);

    // copy byte: forwarded write, stored entry, or never-written entry
    assign copy_d = fwd_reg ? fwd_data_reg : (rvalid_reg ? mem_rdata : 8'h00);

    // next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        tok_idx_next   = tok_idx_reg;
        word_high_next = word_high_reg;
        finished_next  = finished_reg;
        wp_next        = wp_reg;
        full_next      = full_reg;
        end_next       = end_reg;
        src_next       = src_reg;
        rd_left_next   = rd_left_reg;
        emit_left_next = emit_left_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        rvalid_next    = rvalid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_req        = '0;
        do_reset       = 1'b0;

        // result taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!finished_reg)
                    begin
                        unique case (phase_reg)
                            PH_TOKEN:
                            begin
                                if (flags_reg[tok_idx_reg])
                                begin
                                    // literal byte
                                    out_valid_next = 1'b1;
                                    out_data_next  = '{out_byte: b, out_kind: KIND_DATA,
                                                       run_last: 1'b1};
                                    mem_req.we     = 1'b1;
                                    mem_req.waddr  = wp_reg;
                                    mem_req.wdata  = b;
                                    wp_next        = wp_reg + 1'b1;
                                    if (wp_reg == {WIN_AW{1'b1}})
                                    begin
                                        full_next = 1'b1;
                                    end
                                    tok_idx_next = tok_idx_reg + 1'b1;
                                    phase_next   = (tok_idx_reg == 3'd7) ? PH_FLAG : PH_TOKEN;
                                end
                                else if (!e)
                                begin
                                    word_high_next = b;
                                    phase_next     = PH_WORD;
                                end
                            end
                            PH_WORD:
                            begin
                                if (word == 16'h0000)
                                begin
                                    // end marker
                                    out_valid_next = 1'b1;
                                    out_data_next  = '{out_byte: 8'h00, out_kind: KIND_END,
                                                       run_last: 1'b1};
                                    finished_next  = 1'b1;
                                end
                                else
                                begin
                                    // start a match copy with the first read
                                    mem_req.re     = 1'b1;
                                    mem_req.raddr  = start_src;
                                    rvalid_next    = full_reg || (start_src < wp_reg);
                                    fwd_next       = 1'b0;
                                    src_next       = start_src + 1'b1;
                                    rd_left_next   = len - 1'b1;
                                    emit_left_next = len;
                                    end_next       = e;
                                    state_next     = ST_COPY;
                                end
                            end
                            default:
                            begin
                                // flag byte, also for the unused phase code
                                flags_next   = b;
                                tok_idx_next = 3'd0;
                                phase_next   = PH_TOKEN;
                            end
                        endcase
                    end
                    if (e && (state_next == ST_IDLE))
                    begin
                        do_reset = 1'b1;
                    end
                end
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    // emit and write back one copied byte
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: copy_d, out_kind: KIND_DATA,
                                       run_last: (emit_left_reg == LEN_W'(1))};
                    mem_req.we     = 1'b1;
                    mem_req.waddr  = wp_reg;
                    mem_req.wdata  = copy_d;
                    wp_next        = wp_reg + 1'b1;
                    if (wp_reg == {WIN_AW{1'b1}})
                    begin
                        full_next = 1'b1;
                    end

                    // next read, forwarded when it hits the entry written now
                    if (rd_left_reg != '0)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = src_reg;
                        fwd_next      = (src_reg == wp_reg);
                        fwd_data_next = copy_d;
                        rvalid_next   = full_reg || (src_reg < wp_reg);
                        src_next      = src_reg + 1'b1;
                        rd_left_next  = rd_left_reg - 1'b1;
                    end

                    emit_left_next = emit_left_reg - 1'b1;
                    if (emit_left_reg == LEN_W'(1))
                    begin
                        tok_idx_next = tok_idx_reg + 1'b1;
                        phase_next   = (tok_idx_reg == 3'd7) ? PH_FLAG : PH_TOKEN;
                        state_next   = ST_IDLE;
                        if (end_reg)
                        begin
                            do_reset = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of stream: back to a fresh, empty window
        if (do_reset)
        begin
            wp_next        = '0;
            full_next      = 1'b0;
            flags_next     = 8'h00;
            tok_idx_next   = 3'd0;
            phase_next     = PH_FLAG;
            word_high_next = 8'h00;
            finished_next  = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FLAG;
            flags_reg     <= 8'h00;
            tok_idx_reg   <= 3'd0;
            word_high_reg <= 8'h00;
            finished_reg  <= 1'b0;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            end_reg       <= 1'b0;
            rd_left_reg   <= '0;
            emit_left_reg <= '0;
            fwd_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            tok_idx_reg   <= tok_idx_next;
            word_high_reg <= word_high_next;
            finished_reg  <= finished_next;
            wp_reg        <= wp_next;
            full_reg      <= full_next;
            end_reg       <= end_next;
            rd_left_reg   <= rd_left_next;
            emit_left_reg <= emit_left_next;
            fwd_reg       <= fwd_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/lzss_byte_decompressor_top.sv
// top level of the lzss byte decompressor
// depends on lzss_pkg, lzss_stream_if, lzss_window_ram, lzss_ctrl
//
// usage
//   stream: compressed bytes (in_byte, stream_end) on a valid/ready channel;
//     stream_end marks the last byte of one compressed stream
//   result: decompressed bytes (out_byte, out_kind, run_last) on a valid/ready
//     channel; out_kind flags the end marker, run_last the last result of a token
// token handling
//   a flag byte, literal or end marker is handled on its own accept; a literal
//   or end marker shows on result the cycle after it is accepted
//   a match word (len 3 to 18) starts the window read of its first byte, then
//   copies one byte per cycle while the output register is free, bounded by the
//   single write port of the 4096-byte window that each data byte is written to
// reset and stalls
//   reset empties the window through a fill count; entries never written since
//   reset or since the last stream end read as zero
//   a stalled result holds in the output register; the copy pauses and no new
//   byte is taken until the output register can take the next request
`timescale 1ns / 1ps

module lzss_byte_decompressor_top
    import lzss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lzss_stream_if.sink   stream,
    lzss_stream_if.source result
);

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;

    // parser and copy sequencer
    lzss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // history window
    lzss_window_ram u_window (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
